>>> hdl/hpa_pkg.sv
`default_nettype none

package hpa_pkg;

    // Handle field and pool sizing
    localparam int HANDLE_W     = 8;
    localparam int HANDLE_SPACE = 1 << HANDLE_W;
    localparam int COUNT_W      = HANDLE_W + 1;

    // Command codes (tuser on the request side)
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_TRY   = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;

    // Status codes (low bits of tuser on the result side)
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NONE       = 2'd1;
    localparam logic [1:0] ST_NOT_IN_USE = 2'd2;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic                reused;
        logic [1:0]          status;
        logic [HANDLE_W-1:0] granted;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/handle_pool_allocator.sv
// Handle pool allocator. Each request (tuser = command, tdata = handle to
// release) gives exactly one result (tdata = granted handle, tuser = status
// and reused flag). Allocate hands out the oldest released handle, or else
// the next never-used one up to NUM_HANDLES (at most 256); try-allocate
// only reuses; deallocate of a handle that is not in use is refused with
// status 2. The in-use bitmap and the release queue sit in single-port
// synchronous memories, so a request runs in two steps: a read of both
// memories, then an update of them and a load of the result register. A
// new request is accepted only after the update; a result that waits in the
// output register does not block acceptance, but the next update waits.
// After reset, the bitmap is cleared by a pass over all 256 entries during
// which no request is accepted.
`default_nettype none

module handle_pool_allocator #(
    parameter int NUM_HANDLES = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [hpa_pkg::HANDLE_W-1:0]  s_axis_tdata,  // [7:0] handle
    input  logic [1:0]                    s_axis_tuser,  // [1:0] cmd
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [hpa_pkg::HANDLE_W-1:0]  m_axis_tdata,  // [7:0] granted_handle
    output logic [2:0]                    m_axis_tuser   // [1:0] status, [2] reused
);
    import hpa_pkg::*;

    localparam logic [COUNT_W-1:0] POOL_LIMIT =
        COUNT_W'((NUM_HANDLES < HANDLE_SPACE) ? NUM_HANDLES : HANDLE_SPACE);

    // Memories
    logic                r_map_mem   [HANDLE_SPACE];
    logic [HANDLE_W-1:0] r_queue_mem [HANDLE_SPACE];
    logic                r_map_rd;
    logic [HANDLE_W-1:0] r_queue_rd;

    // Control and pointers
    t_state              r_state, n_state;
    logic [HANDLE_W-1:0] r_clr_addr, n_clr_addr;
    logic [HANDLE_W-1:0] r_head, n_head;
    logic [HANDLE_W-1:0] r_tail, n_tail;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [COUNT_W-1:0]  r_fresh, n_fresh;
    logic [1:0]          r_cmd;
    logic [HANDLE_W-1:0] r_handle;
    t_result             r_out, n_out;
    logic                r_out_valid, n_out_valid;

    // Memory write ports
    logic                map_we;
    logic [HANDLE_W-1:0] map_waddr;
    logic                map_wdata;
    logic                queue_we;

    logic accept;
    logic out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.granted;
    assign m_axis_tuser  = {r_out.reused, r_out.status};

    // Next state, memory writes and result
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_fresh     = r_fresh;
        n_out       = r_out;
        n_out_valid = r_out_valid && !m_axis_tready;
        map_we      = 1'b0;
        map_waddr   = r_handle;
        map_wdata   = 1'b0;
        queue_we    = 1'b0;

        case (r_state)
            S_CLEAR: begin
                map_we     = 1'b1;
                map_waddr  = r_clr_addr;
                map_wdata  = 1'b0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    case (r_cmd)
                        CMD_ALLOC, CMD_TRY: begin
                            if (r_count != '0) begin
                                // reuse the oldest released handle
                                map_we      = 1'b1;
                                map_waddr   = r_queue_rd;
                                map_wdata   = 1'b1;
                                n_head      = r_head + 1'b1;
                                n_count     = r_count - 1'b1;
                                n_out.granted = r_queue_rd;
                                n_out.status  = ST_OK;
                                n_out.reused  = 1'b1;
                            end else if (r_cmd == CMD_ALLOC && r_fresh < POOL_LIMIT) begin
                                // take a never-used handle
                                map_we      = 1'b1;
                                map_waddr   = r_fresh[HANDLE_W-1:0];
                                map_wdata   = 1'b1;
                                n_fresh     = r_fresh + 1'b1;
                                n_out.granted = r_fresh[HANDLE_W-1:0];
                                n_out.status  = ST_OK;
                            end else begin
                                n_out.status = ST_NONE;
                            end
                        end
                        CMD_FREE: begin
                            if (!r_map_rd) begin
                                n_out.status = ST_NOT_IN_USE;
                            end else begin
                                map_we    = 1'b1;
                                map_waddr = r_handle;
                                map_wdata = 1'b0;
                                queue_we  = 1'b1;
                                n_tail    = r_tail + 1'b1;
                                n_count   = r_count + 1'b1;
                                n_out.status = ST_OK;
                            end
                        end
                        default: begin
                            n_out = '0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // In-use bitmap memory
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[map_waddr] <= map_wdata;
        end
        if (accept) begin
            r_map_rd <= r_map_mem[s_axis_tdata];
        end
    end

    // Release queue memory
    always_ff @(posedge i_clk) begin
        if (queue_we) begin
            r_queue_mem[r_tail] <= r_handle;
        end
        if (accept) begin
            r_queue_rd <= r_queue_mem[r_head];
        end
    end

    // Request capture and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= s_axis_tuser;
            r_handle <= s_axis_tdata;
        end
        r_out <= n_out;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

>>> hdl/hpa_checker.sv
`default_nettype none

module hpa_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          s_axis_tvalid,
    input wire                          s_axis_tready,
    input wire [hpa_pkg::HANDLE_W-1:0]  s_axis_tdata,
    input wire [1:0]                    s_axis_tuser,
    input wire                          m_axis_tvalid,
    input wire                          m_axis_tready,
    input wire [hpa_pkg::HANDLE_W-1:0]  m_axis_tdata,
    input wire [2:0]                    m_axis_tuser
);
    import hpa_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a nonzero handle is only granted with status ok
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata != '0 |-> m_axis_tuser[1:0] == ST_OK)
        else $error("handle granted with error status");

    // reused flag only with status ok
    a_reuse_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == ST_OK)
        else $error("reused flag with error status");

    // status code is never the unused encoding
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser[1:0] != 2'd3)
        else $error("undefined status code");

    // the engine is busy the cycle after taking a request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while previous one in flight");

endmodule

bind handle_pool_allocator hpa_checker u_hpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
